/* hw/rtl/cidr_acl_match_assert.svh */
// Assertion macros shared by the CIDR access list RTL.
`ifndef CIDR_ACL_MATCH_ASSERT_SVH
`define CIDR_ACL_MATCH_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CACL_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("cidr_acl_match: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CACL_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("cidr_acl_match: assertion failed");

`endif

/* hw/rtl/cacl_pkg.sv */
// Types and constants of the CIDR access list matcher.
`default_nettype none
package cacl_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_CHECK = 2'd2
    } t_action;

    localparam logic [7:0]  V4_PREFIX_MAX = 8'd32;
    localparam logic [7:0]  V6_PREFIX_MAX = 8'd128;
    // upper half of address_lo for an IPv4-mapped IPv6 address
    localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

    // one stored slot; IPv4 entries keep mask and network in bits 31..0
    typedef struct packed {
        logic         is_v6;
        logic [127:0] mask;
        logic [127:0] net;
    } t_entry;

    typedef struct packed {
        logic         is_v6;
        logic [63:0]  hi;
        logic [63:0]  lo;
    } t_addr;

endpackage
`default_nettype wire

/* hw/rtl/cacl_if.sv */
// Request and result channel interfaces of the CIDR access list matcher.
`default_nettype none
interface cacl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  entry_index;
    logic        is_v6;
    logic [7:0]  prefix_bits;
    logic [63:0] address_hi;
    logic [63:0] address_lo;

    modport source (output valid, action, entry_index, is_v6, prefix_bits,
                    address_hi, address_lo, input ready);
    modport sink   (input valid, action, entry_index, is_v6, prefix_bits,
                    address_hi, address_lo, output ready);
endinterface

interface cacl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;
    logic load_rejected;

    modport source (output valid, allowed, load_rejected, input ready);
    modport sink   (input valid, allowed, load_rejected, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cacl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/cacl_cmp.sv */
// Shared masked comparator: does one stored slot contain the address.
`default_nettype none
module cacl_cmp
    import cacl_pkg::*;
(
    input  wire t_entry i_entry,
    input  wire t_addr  i_addr,
    output logic        o_hit
);

    logic fam_ok;
    logic mapped;

    always_comb begin
        mapped = (i_addr.hi == 64'd0) && (i_addr.lo[63:32] == V4_MAPPED_TAG);
        if (i_entry.is_v6) begin
            fam_ok = i_addr.is_v6;
        end else begin
            fam_ok = !i_addr.is_v6 || mapped;
        end
        // IPv4 slots have zero mask above bit 31, so the upper bits drop out
        o_hit = fam_ok && (({i_addr.hi, i_addr.lo} & i_entry.mask) == i_entry.net);
    end

endmodule
`default_nettype wire

/* hw/rtl/cidr_acl_match.sv */
// CIDR access list matcher: slot table, scan sequencer and result register.
//
// Requests arrive on i_req (valid/ready); each gives exactly one result on
// o_rsp. action LOAD stores a slot with its network masked to the prefix
// (load_rejected is set and the slot kept if the prefix is longer than 32
// for IPv4 or 128 for IPv6), CLEAR empties the table, CHECK reports
// allowed when any valid slot contains the address.
// Slots live in a RAM with registered read; valid bits are flip-flops.
// A CHECK walks every slot through one shared masked comparator, one slot
// per cycle in S_SCAN after S_EXEC; S_DRAIN and S_RESULT then follow.
// LOAD, CLEAR and unused codes go from S_EXEC straight to S_RESULT. One
// request is in work at a time; i_req.ready is high only between requests,
// so a new request is taken only after the last result has been registered.
// The result sits in an output register, so the next request is taken
// while a result still waits; a stalled o_rsp holds its result and the
// block finishes the next request but waits before writing it over.
// Reset (synchronous, active low) empties the table at once; no sweep.
`default_nettype none
module cidr_acl_match
    import cacl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cacl_req_if.sink    i_req,
    cacl_rsp_if.source  o_rsp
);

    `include "cidr_acl_match_assert.svh"

    localparam int         IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [8:0] ENT9   = 9'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_hit, n_hit;
    logic              r_rej, n_rej;
    logic              r_ovalid, n_ovalid;
    logic              r_oallowed, r_orej;

    // captured request
    logic [1:0]        r_act;
    logic [3:0]        r_idx;
    logic [7:0]        r_pfx;
    t_addr             r_addr;

    logic              accept;
    logic              too_long;
    logic              in_range;
    logic              ram_we;
    logic [8:0]        idx9;
    logic [IDX_W-1:0]  ram_waddr;
    logic [127:0]      m6;
    logic [31:0]       m4;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic              cmp_hit;
    logic              out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.allowed       = r_oallowed;
    assign o_rsp.load_rejected = r_orej;

    // load path: mask the network to the prefix
    always_comb begin
        too_long  = r_pfx > (r_addr.is_v6 ? V6_PREFIX_MAX : V4_PREFIX_MAX);
        idx9      = {5'b0, r_idx};
        in_range  = idx9 < ENT9;
        ram_waddr = idx9[IDX_W-1:0];
        m6        = ~({128{1'b1}} >> r_pfx);
        m4        = ~(32'hFFFF_FFFF >> r_pfx);
        wr_entry.is_v6 = r_addr.is_v6;
        if (r_addr.is_v6) begin
            wr_entry.mask = m6;
            wr_entry.net  = {r_addr.hi, r_addr.lo} & m6;
        end else begin
            wr_entry.mask = {96'd0, m4};
            wr_entry.net  = {96'd0, r_addr.lo[31:0] & m4};
        end
        ram_we = (r_state == S_EXEC) && (r_act == ACT_LOAD) && !too_long && in_range;
    end

    cacl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_cnt),
        .o_rdata (rd_entry)
    );

    cacl_cmp u_cmp (
        .i_entry (rd_entry),
        .i_addr  (r_addr),
        .o_hit   (cmp_hit)
    );

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_cnt    = r_cnt;
        n_pend   = 1'b0;
        n_hit    = r_hit;
        n_rej    = r_rej;
        n_ovalid = r_ovalid && !o_rsp.ready;

        // read data of the slot issued last cycle
        if (r_pend && r_valid[r_pidx] && cmp_hit) begin
            n_hit = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_hit   = 1'b0;
                n_rej   = 1'b0;
                n_cnt   = '0;
                n_state = S_RESULT;
                case (r_act)
                    ACT_LOAD: begin
                        n_rej = too_long;
                        if (ram_we) begin
                            n_valid[ram_waddr] = 1'b1;
                        end
                    end
                    ACT_CLEAR: n_valid = '0;
                    ACT_CHECK: n_state = S_SCAN;
                    default: ;
                endcase
            end
            S_SCAN: begin
                n_pend = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_hit    <= 1'b0;
            r_rej    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_hit    <= n_hit;
            r_rej    <= n_rej;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt;
        if (accept) begin
            r_act        <= i_req.action;
            r_idx        <= i_req.entry_index;
            r_pfx        <= i_req.prefix_bits;
            r_addr.is_v6 <= i_req.is_v6;
            r_addr.hi    <= i_req.address_hi;
            r_addr.lo    <= i_req.address_lo;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_oallowed <= r_hit;
            r_orej     <= r_rej;
        end
    end

    `CACL_ASSERT_NXT(a_accept_exec, accept, r_state == S_EXEC)
    `CACL_ASSERT_IMP(a_one_flag, o_rsp.valid, !(o_rsp.allowed && o_rsp.load_rejected))
    `CACL_ASSERT_NXT(a_scan_table_stable, r_state == S_SCAN, $stable(r_valid))
    `CACL_ASSERT_NXT(a_result_out, (r_state == S_RESULT) && out_free, o_rsp.valid)

endmodule
`default_nettype wire
